// ----- rtl/core/mpda_pkg.sv -----
// ----------------------------------------------------------------------------
// mpda_pkg
// Shared types, constants and element decoders for the mixed-precision
// dot-product accumulator.
// ----------------------------------------------------------------------------
package mpda_pkg;

    // Exponent width used for all unpacked values (signed, weight of the lsb).
    localparam int EXP_W       = 12;
    // Significand width of the double-precision accumulator.
    localparam int SIG_W       = 53;
    // Significand width of one decoded FP32/FP16/BF16 element.
    localparam int ELEM_MW     = 24;
    // Width of the exact product of two element significands.
    localparam int PROD_W      = 2 * ELEM_MW;
    // Default depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

    localparam logic signed [EXP_W-1:0] FP32_EMAX = EXP_W'(127);
    localparam logic signed [EXP_W-1:0] FP32_EMIN = -EXP_W'(126);

    // Weight encodings selected by the configuration register.
    typedef enum logic [1:0] {
        WF_FP32 = 2'd0,
        WF_FP16 = 2'd1,
        WF_BF16 = 2'd2
    } t_wfmt;

    // One decoded element: value = man * 2^exp unless nan or inf.
    typedef struct packed {
        logic                    nan;
        logic                    inf;
        logic                    sign;
        logic                    zero;
        logic signed [EXP_W-1:0] exp;
        logic [ELEM_MW-1:0]      man;
    } t_elem;

    // Normalized product or accumulator: value = sig * 2^exp, sig[msb] set
    // unless zero.
    typedef struct packed {
        logic                    nan;
        logic                    inf;
        logic                    sign;
        logic                    zero;
        logic                    last;
        logic signed [EXP_W-1:0] exp;
        logic [SIG_W-1:0]        sig;
    } t_prod;

    // Decode an FP32 word into an unnormalized significand and exponent.
    function automatic t_elem f_dec_fp32(input logic [31:0] b);
        t_elem d;
        d.sign = b[31];
        d.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        d.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (b[30:23] == 8'd0) begin
            d.man = {1'b0, b[22:0]};
            d.exp = -EXP_W'(149);
        end else begin
            d.man = {1'b1, b[22:0]};
            d.exp = $signed({{(EXP_W-8){1'b0}}, b[30:23]}) - $signed(EXP_W'(150));
        end
        d.zero = (d.man == '0);
        return d;
    endfunction

    // Decode an FP16 word; subnormals stay exact as an unnormalized value.
    function automatic t_elem f_dec_fp16(input logic [15:0] h);
        t_elem d;
        d.sign = h[15];
        d.nan  = (h[14:10] == 5'd31) && (h[9:0] != 10'd0);
        d.inf  = (h[14:10] == 5'd31) && (h[9:0] == 10'd0);
        if (h[14:10] == 5'd0) begin
            d.man = {14'd0, h[9:0]};
            d.exp = -EXP_W'(24);
        end else begin
            d.man = {13'd0, 1'b1, h[9:0]};
            d.exp = $signed({{(EXP_W-5){1'b0}}, h[14:10]}) - $signed(EXP_W'(25));
        end
        d.zero = (d.man == '0);
        return d;
    endfunction

endpackage

// ----- rtl/core/mpda_if.sv -----
// ----------------------------------------------------------------------------
// mpda_if
// Valid/ready channel interfaces for element pairs and dot-product results.
// ----------------------------------------------------------------------------
interface mpda_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] weight_bits;
    logic [31:0] activation_bits;
    logic        last_element;

    modport source (output valid, output weight_bits, output activation_bits,
                    output last_element, input ready);
    modport sink   (input valid, input weight_bits, input activation_bits,
                    input last_element, output ready);
endinterface

interface mpda_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

// ----- rtl/core/mixed_precision_dot_accumulator.sv -----
// ----------------------------------------------------------------------------
// mixed_precision_dot_accumulator
// Streams weight/activation pairs, accumulates exact products in double
// precision and emits each finished dot product rounded to FP32.
//
//   Channel   Dir  Payload                                          Accepted
//   i_dot     in   weight_bits, activation_bits, last_element       valid & ready
//   o_dot     out  result_bits                                      valid & ready
//   i_cfg_*   in   i_cfg_wdata = weight format                      i_cfg_we
//
// The front end takes one transaction per cycle until the product queue is
// full. The accumulator holds one pair at a time: its add loop runs
// align/add, then normalize/round, and the new sum feeds the following add.
// A closing pair passes the front-end stages, the queue, the align/add
// register, the snapshot and the output register to reach o_dot. Reset is
// synchronous and clears all control state; the sum starts at positive zero.
// A stalled o_dot backs up through the snapshot and the queue to i_dot.ready.
// ----------------------------------------------------------------------------
module mixed_precision_dot_accumulator #(
    parameter int QUEUE_DEPTH = mpda_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpda_in_if.sink    i_dot,
    mpda_out_if.source o_dot,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);
    import mpda_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             w_push;
    t_prod            w_push_data;
    logic             w_pop;
    logic             w_q_valid;
    t_prod            w_head;
    logic [CNT_W-1:0] w_q_count;

    // Decode and multiply.
    mpda_front #(
        .QDEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dot       (i_dot),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_count   (w_q_count),
        .o_push      (w_push),
        .o_prod      (w_push_data)
    );

    // Product queue.
    mpda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head),
        .o_count (w_q_count)
    );

    // Accumulate and round.
    mpda_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_head    (w_head),
        .o_pop     (w_pop),
        .o_dot     (o_dot)
    );

endmodule

// ----- rtl/core/mpda_front.sv -----
// ----------------------------------------------------------------------------
// mpda_front
// Accepts element pairs, decodes the weight format, forms the exact product
// and normalizes it before it enters the queue.
// ----------------------------------------------------------------------------
module mpda_front #(
    parameter int  QDEPTH = mpda_pkg::QUEUE_DEPTH,
    localparam int CNT_W  = $clog2(QDEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mpda_in_if.sink           i_dot,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    input  logic [CNT_W-1:0]  i_q_count,
    output logic              o_push,
    output mpda_pkg::t_prod   o_prod
);
    import mpda_pkg::*;

    t_wfmt                   r_wfmt;
    logic                    r_f1_v;
    logic                    r_f1_nan;
    logic                    r_f1_inf;
    logic                    r_f1_sign;
    logic                    r_f1_last;
    logic signed [EXP_W-1:0] r_f1_exp;
    logic [PROD_W-1:0]       r_f1_mag;
    logic                    r_f2_v;
    t_prod                   r_f2;
    t_prod                   n_f2;

    logic [CNT_W:0] w_used;
    logic           w_accept;
    t_elem          w_wt;
    t_elem          w_act;
    logic [5:0]     w_lz;

    // Weight format register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wfmt <= WF_FP32;
        end else if (i_cfg_we) begin
            r_wfmt <= t_wfmt'(i_cfg_wdata);
        end
    end

    // Take a transaction only while the queue has room for everything in flight.
    assign w_used      = {1'b0, i_q_count} + (CNT_W+1)'(r_f1_v) + (CNT_W+1)'(r_f2_v);
    assign i_dot.ready = (w_used < (CNT_W+1)'(QDEPTH));
    assign w_accept    = i_dot.valid && i_dot.ready;

    // Element decode.
    always_comb begin
        unique case (r_wfmt)
            WF_FP16: w_wt = f_dec_fp16(i_dot.weight_bits[15:0]);
            WF_BF16: w_wt = f_dec_fp32({i_dot.weight_bits[15:0], 16'h0000});
            default: w_wt = f_dec_fp32(i_dot.weight_bits);
        endcase
        w_act = f_dec_fp32(i_dot.activation_bits);
    end

    // Stage 1: exact significand product and special-value classification.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else begin
            r_f1_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_nan  <= w_wt.nan | w_act.nan | (w_wt.inf & w_act.zero) |
                     (w_act.inf & w_wt.zero);
        r_f1_inf  <= w_wt.inf | w_act.inf;
        r_f1_sign <= w_wt.sign ^ w_act.sign;
        r_f1_last <= i_dot.last_element;
        r_f1_exp  <= w_wt.exp + w_act.exp;
        r_f1_mag  <= w_wt.man * w_act.man;
    end

    // Leading-zero count of the product.
    always_comb begin
        w_lz = 6'd0;
        for (int i = 0; i < PROD_W; i++) begin
            if (r_f1_mag[i]) begin
                w_lz = 6'(PROD_W - 1 - i);
            end
        end
    end

    // Stage 2: normalize so the leading one sits at the accumulator msb.
    always_comb begin
        n_f2.nan  = r_f1_nan;
        n_f2.inf  = r_f1_inf;
        n_f2.sign = r_f1_sign;
        n_f2.zero = (r_f1_mag == '0);
        n_f2.last = r_f1_last;
        n_f2.sig  = {r_f1_mag, {(SIG_W-PROD_W){1'b0}}} << w_lz;
        n_f2.exp  = r_f1_exp - $signed(EXP_W'(SIG_W - PROD_W))
                    - $signed({{(EXP_W-6){1'b0}}, w_lz});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2 <= n_f2;
    end

    assign o_push = r_f2_v;
    assign o_prod = r_f2;

endmodule

// ----- rtl/core/mpda_queue.sv -----
// ----------------------------------------------------------------------------
// mpda_queue
// Small register FIFO of normalized products between front and back end.
// ----------------------------------------------------------------------------
module mpda_queue #(
    parameter int  DEPTH = mpda_pkg::QUEUE_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mpda_pkg::t_prod  i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output mpda_pkg::t_prod  o_head,
    output logic [CNT_W-1:0] o_count
);
    import mpda_pkg::*;

    t_prod            r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr;
    logic [IDX_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

// ----- rtl/core/mpda_back.sv -----
// ----------------------------------------------------------------------------
// mpda_back
// Double-precision accumulator (align/add, then normalize/round), FP32
// conversion of a finished sum and the result output register.
// ----------------------------------------------------------------------------
module mpda_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  mpda_pkg::t_prod i_head,
    output logic            o_pop,
    mpda_out_if.source      o_dot
);
    import mpda_pkg::*;

    localparam int EXT_W = SIG_W + 3;

    t_prod                   r_acc;
    t_prod                   n_acc;
    logic                    r_s1_v;
    logic [EXT_W:0]          r_s1_sum;
    logic signed [EXP_W-1:0] r_s1_exp;
    logic                    r_s1_sign;
    logic                    r_s1_nan;
    logic                    r_s1_inf;
    logic                    r_s1_isign;
    logic                    r_s1_last;
    logic                    r_sn_v;
    t_prod                   r_sn;
    logic                    r_out_v;
    logic [31:0]             r_out_bits;

    logic                    w_issue;
    logic                    w_s2_fire;
    logic                    w_sn_move;
    logic                    w_sn_free;

    logic                    w_a_big;
    logic [SIG_W-1:0]        w_big_sig;
    logic [SIG_W-1:0]        w_small_sig;
    logic signed [EXP_W-1:0] w_big_exp;
    logic signed [EXP_W-1:0] w_small_exp;
    logic                    w_big_sign;
    logic                    w_small_zero;
    logic signed [EXP_W-1:0] w_diff;
    logic [5:0]              w_sh;
    logic [EXT_W-1:0]        w_ext;
    logic [EXT_W-1:0]        w_shifted;
    logic [EXT_W-1:0]        w_aligned;
    logic [EXT_W:0]          w_sum;
    logic                    w_nan;
    logic                    w_inf;

    logic [5:0]              w_lz;
    logic [EXT_W-1:0]        w_nrm;
    logic signed [EXP_W-1:0] w_nexp;
    logic                    w_up;
    logic [SIG_W:0]          w_rsum;

    // Round a normalized double value to FP32 bits, nearest even.
    function automatic logic [31:0] f_to_fp32(input t_prod s);
        logic signed [EXP_W-1:0] e_unb;
        logic signed [EXP_W-1:0] e_tmp;
        logic [5:0]              sh;
        logic [30:0]             field;
        logic [SIG_W-1:0]        q;
        logic [SIG_W-1:0]        gv;
        logic [SIG_W-1:0]        mask;
        logic                    st;
        logic                    up;
        logic [30:0]             mag;
        e_unb = s.exp + $signed(EXP_W'(SIG_W - 1));
        if (e_unb >= FP32_EMIN) begin
            e_tmp = e_unb - FP32_EMIN;
            sh    = 6'(SIG_W - ELEM_MW);
            field = {e_tmp[7:0], 23'd0};
        end else begin
            e_tmp = $signed(EXP_W'(SIG_W - ELEM_MW)) + FP32_EMIN - e_unb;
            sh    = (e_tmp > $signed(EXP_W'(63))) ? 6'd63 : e_tmp[5:0];
            field = '0;
        end
        q    = s.sig >> sh;
        gv   = s.sig >> (sh - 6'd1);
        mask = (SIG_W'(1) << (sh - 6'd1)) - SIG_W'(1);
        st   = |(s.sig & mask);
        up   = gv[0] & (st | q[0]);
        mag  = field + 31'(q) + 31'(up);
        if (s.nan) begin
            return CANON_NAN;
        end else if (s.inf || (!s.zero && e_unb > FP32_EMAX)) begin
            return {s.sign, INF_MAG};
        end else if (s.zero) begin
            return {s.sign, 31'd0};
        end
        return {s.sign, mag};
    endfunction

    // Flow control: one accumulate in flight, snapshot and output register.
    assign w_issue   = i_q_valid && !r_s1_v;
    assign o_pop     = w_issue;
    assign w_sn_move = r_sn_v && (!r_out_v || o_dot.ready);
    assign w_sn_free = !r_sn_v || w_sn_move;
    assign w_s2_fire = r_s1_v && (!r_s1_last || w_sn_free);

    // Step 1: order by magnitude, align the smaller operand, add.
    always_comb begin
        w_a_big = i_head.zero ||
                  (!r_acc.zero && ((r_acc.exp > i_head.exp) ||
                   ((r_acc.exp == i_head.exp) && (r_acc.sig >= i_head.sig))));
        w_big_sig    = w_a_big ? r_acc.sig  : i_head.sig;
        w_big_exp    = w_a_big ? r_acc.exp  : i_head.exp;
        w_big_sign   = w_a_big ? r_acc.sign : i_head.sign;
        w_small_sig  = w_a_big ? i_head.sig : r_acc.sig;
        w_small_exp  = w_a_big ? i_head.exp : r_acc.exp;
        w_small_zero = w_a_big ? i_head.zero : r_acc.zero;
        w_diff       = w_big_exp - w_small_exp;
        w_sh         = (w_diff > $signed(EXP_W'(63))) ? 6'd63 : w_diff[5:0];
        w_ext        = {w_small_sig, 3'b000};
        w_shifted    = w_ext >> w_sh;
        w_aligned    = w_small_zero ? '0 :
                       (w_shifted | EXT_W'((w_shifted << w_sh) != w_ext));
        if (r_acc.sign ^ i_head.sign) begin
            w_sum = {1'b0, w_big_sig, 3'b000} - {1'b0, w_aligned};
        end else begin
            w_sum = {1'b0, w_big_sig, 3'b000} + {1'b0, w_aligned};
        end
        w_nan = r_acc.nan | i_head.nan |
                (r_acc.inf & i_head.inf & (r_acc.sign != i_head.sign));
        w_inf = !w_nan && (r_acc.inf || i_head.inf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_issue) begin
            r_s1_v <= 1'b1;
        end else if (w_s2_fire) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s1_sum   <= w_sum;
            r_s1_exp   <= w_big_exp;
            r_s1_sign  <= w_big_sign;
            r_s1_nan   <= w_nan;
            r_s1_inf   <= w_inf;
            r_s1_isign <= r_acc.inf ? r_acc.sign : i_head.sign;
            r_s1_last  <= i_head.last;
        end
    end

    // Leading-zero count below the carry bit.
    always_comb begin
        w_lz = 6'd0;
        for (int i = 0; i < EXT_W; i++) begin
            if (r_s1_sum[i]) begin
                w_lz = 6'(EXT_W - 1 - i);
            end
        end
    end

    // Step 2: normalize and round to nearest even.
    always_comb begin
        if (r_s1_sum[EXT_W]) begin
            w_nrm  = r_s1_sum[EXT_W:1] | EXT_W'(r_s1_sum[0]);
            w_nexp = r_s1_exp + $signed(EXP_W'(1));
        end else begin
            w_nrm  = r_s1_sum[EXT_W-1:0] << w_lz;
            w_nexp = r_s1_exp - $signed({{(EXP_W-6){1'b0}}, w_lz});
        end
        w_up   = w_nrm[2] & (w_nrm[1] | w_nrm[0] | w_nrm[3]);
        w_rsum = {1'b0, w_nrm[EXT_W-1:3]} + (SIG_W+1)'(w_up);

        n_acc.nan  = r_s1_nan;
        n_acc.inf  = r_s1_inf;
        n_acc.zero = (r_s1_sum == '0);
        n_acc.last = r_s1_last;
        if (r_s1_nan || r_s1_inf) begin
            n_acc.sign = r_s1_isign;
        end else begin
            n_acc.sign = n_acc.zero ? 1'b0 : r_s1_sign;
        end
        if (w_rsum[SIG_W]) begin
            n_acc.sig = {1'b1, {(SIG_W-1){1'b0}}};
            n_acc.exp = w_nexp + $signed(EXP_W'(1));
        end else begin
            n_acc.sig = w_rsum[SIG_W-1:0];
            n_acc.exp = w_nexp;
        end
    end

    // Accumulator state; a closing transaction leaves positive zero behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc.nan  <= 1'b0;
            r_acc.inf  <= 1'b0;
            r_acc.sign <= 1'b0;
            r_acc.zero <= 1'b1;
            r_acc.last <= 1'b0;
        end else if (w_s2_fire) begin
            if (r_s1_last) begin
                r_acc.nan  <= 1'b0;
                r_acc.inf  <= 1'b0;
                r_acc.sign <= 1'b0;
                r_acc.zero <= 1'b1;
                r_acc.last <= 1'b0;
            end else begin
                r_acc.nan  <= n_acc.nan;
                r_acc.inf  <= n_acc.inf;
                r_acc.sign <= n_acc.sign;
                r_acc.zero <= n_acc.zero;
                r_acc.last <= n_acc.last;
            end
        end
    end

    // A zero sum keeps an all-zero significand, so adding a zero product
    // to it yields zero again.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_s2_fire && r_s1_last)) begin
            r_acc.exp <= '0;
            r_acc.sig <= '0;
        end else if (w_s2_fire) begin
            r_acc.exp <= n_acc.exp;
            r_acc.sig <= n_acc.sig;
        end
    end

    // Snapshot of a finished sum waiting for conversion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn_v <= 1'b0;
        end else if (w_s2_fire && r_s1_last) begin
            r_sn_v <= 1'b1;
        end else if (w_sn_move) begin
            r_sn_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_fire && r_s1_last) begin
            r_sn <= n_acc;
        end
    end

    // Step 3: FP32 rounding into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_sn_move) begin
            r_out_v <= 1'b1;
        end else if (o_dot.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sn_move) begin
            r_out_bits <= f_to_fp32(r_sn);
        end
    end

    assign o_dot.valid       = r_out_v;
    assign o_dot.result_bits = r_out_bits;

endmodule
